@@ hw/rtl/itrs_pkg.sv @@
// Shared constants, types and register codes for the integer-to-radix-symbols unit.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package itrs_pkg;

   localparam int VALUE_WIDTH  = 32;
   localparam int CHAR_WIDTH   = 8;
   localparam int CSR_WIDTH    = 64;
   localparam int CSR_INDEX_WIDTH = 2;

   // Alphabet storage is two 64-bit registers of eight bytes each.
   localparam int TABLE_BYTES  = 16;
   localparam int MAX_SYMBOLS  = 16;
   localparam int ALPHA_LEN    = (MAX_SYMBOLS < TABLE_BYTES) ? MAX_SYMBOLS : TABLE_BYTES;

   localparam int DIGIT_WIDTH  = $clog2(TABLE_BYTES);
   localparam int BASE_WIDTH   = $clog2(TABLE_BYTES + 1);
   localparam int NDIG_WIDTH   = $clog2(VALUE_WIDTH + 1);
   localparam int STEP_WIDTH   = $clog2(VALUE_WIDTH);

   localparam logic [CHAR_WIDTH-1:0] MINUS_SIGN = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0] PLUS_SIGN  = 8'h2B;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SYMBOLS_LOW  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SYMBOLS_HIGH = 2'd1;

   typedef logic [TABLE_BYTES-1:0][CHAR_WIDTH-1:0] sym_table_type;

   typedef struct packed {
      logic                   done;
      logic [VALUE_WIDTH-1:0] quotient;
      logic [DIGIT_WIDTH-1:0] remainder;
   } div_result_type;

endpackage

@@ hw/rtl/itrs_alpha_check.sv @@
// Alphabet validation: finds the symbol count and rejects short, signed or repeated alphabets.
// Depends on itrs_pkg.
`timescale 1ns / 1ps

module itrs_alpha_check (
   input  itrs_pkg::sym_table_type             sym_table,
   output logic [itrs_pkg::BASE_WIDTH-1:0]     base
);
   import itrs_pkg::*;

   logic [TABLE_BYTES-1:0] present;
   logic                   bad;
   logic                   prefix;
   logic [BASE_WIDTH-1:0]  len;

   always_comb begin
      present = '0;
      bad     = 1'b0;
      prefix  = 1'b1;
      // A symbol belongs to the alphabet only if no zero byte comes before it.
      for (int i = 0; i < TABLE_BYTES; i++) begin
         if (i < ALPHA_LEN) begin
            prefix = prefix && (sym_table[i] != '0);
         end else begin
            prefix = 1'b0;
         end
         present[i] = prefix;
      end
      for (int a = 0; a < TABLE_BYTES; a++) begin
         if (present[a] && (sym_table[a] == MINUS_SIGN || sym_table[a] == PLUS_SIGN)) begin
            bad = 1'b1;
         end
         for (int b = a + 1; b < TABLE_BYTES; b++) begin
            if (present[b] && (sym_table[a] == sym_table[b])) begin
               bad = 1'b1;
            end
         end
      end
      len  = BASE_WIDTH'($countones(present));
      base = (bad || (len < BASE_WIDTH'(2))) ? '0 : len;
   end

endmodule

@@ hw/rtl/itrs_divider.sv @@
// Restoring divider: one quotient bit per cycle, dividing by a small base.
// Depends on itrs_pkg.
`timescale 1ns / 1ps

module itrs_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [itrs_pkg::VALUE_WIDTH-1:0]  dividend,
   input  logic [itrs_pkg::BASE_WIDTH-1:0]   divisor,
   output itrs_pkg::div_result_type          result
);
   import itrs_pkg::*;

   logic                   busy_ff;
   logic [STEP_WIDTH-1:0]  count_ff;
   logic [VALUE_WIDTH-1:0] quo_ff;
   logic [DIGIT_WIDTH-1:0] rem_ff;
   logic                   done_ff;

   logic [BASE_WIDTH-1:0]  trial;
   logic                   fits;
   logic [BASE_WIDTH-1:0]  diff;
   logic [DIGIT_WIDTH-1:0] rem_in;

   // The remainder stays below the divisor, so the trial value fits in BASE_WIDTH bits.
   always_comb begin
      trial  = {rem_ff, quo_ff[VALUE_WIDTH-1]};
      fits   = (trial >= divisor);
      diff   = trial - divisor;
      rem_in = fits ? diff[DIGIT_WIDTH-1:0] : trial[DIGIT_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
            quo_ff   <= dividend;
            rem_ff   <= '0;
         end else if (busy_ff) begin
            quo_ff   <= {quo_ff[VALUE_WIDTH-2:0], fits};
            rem_ff   <= rem_in;
            count_ff <= count_ff + 1'b1;
            if (count_ff == STEP_WIDTH'(VALUE_WIDTH - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign result.done      = done_ff;
   assign result.quotient  = quo_ff;
   assign result.remainder = rem_ff;

endmodule

@@ hw/rtl/itrs_sequencer.sv @@
// Conversion sequencer: drives the divider once per digit, stacks the digits, then emits text.
// Depends on itrs_pkg.
`timescale 1ns / 1ps

module itrs_sequencer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [itrs_pkg::VALUE_WIDTH-1:0]  req_value,
   input  logic [itrs_pkg::BASE_WIDTH-1:0]   base,
   input  itrs_pkg::sym_table_type           sym_table,
   output logic                              div_start,
   output logic [itrs_pkg::VALUE_WIDTH-1:0]  div_dividend,
   output logic [itrs_pkg::BASE_WIDTH-1:0]   div_divisor,
   input  itrs_pkg::div_result_type          div_result,
   output logic                              rsp_valid,
   output logic [itrs_pkg::CHAR_WIDTH-1:0]   rsp_character,
   output logic                              rsp_last
);
   import itrs_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SIGN,
      ST_EMIT
   } state_type;

   state_type              state_ff;
   logic                   neg_ff;
   logic [BASE_WIDTH-1:0]  base_ff;
   logic                   div_start_ff;
   logic [VALUE_WIDTH-1:0] dividend_ff;
   logic [NDIG_WIDTH-1:0]  ndig_ff;
   logic [DIGIT_WIDTH-1:0] digits_ff [VALUE_WIDTH];
   logic                   rsp_valid_ff;
   logic [CHAR_WIDTH-1:0]  rsp_character_ff;
   logic                   rsp_last_ff;

   logic                   negative;
   logic [VALUE_WIDTH-1:0] magnitude;
   logic [NDIG_WIDTH-1:0]  top_index;

   // Two's complement negation also gives 2^31 for the most negative value.
   assign negative  = req_value[VALUE_WIDTH-1];
   assign magnitude = negative ? (VALUE_WIDTH'(0) - req_value) : req_value;
   assign top_index = ndig_ff - 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ndig_ff      <= '0;
      end else begin
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               // An invalid alphabet reports a base of zero and the request is dropped.
               if (start && (base != '0)) begin
                  neg_ff       <= negative;
                  base_ff      <= base;
                  dividend_ff  <= magnitude;
                  div_start_ff <= 1'b1;
                  ndig_ff      <= '0;
                  state_ff     <= ST_DIVIDE;
               end
            end
            ST_DIVIDE: begin
               if (div_result.done) begin
                  digits_ff[ndig_ff[STEP_WIDTH-1:0]] <= div_result.remainder;
                  ndig_ff <= ndig_ff + 1'b1;
                  if ((div_result.quotient != '0) && (ndig_ff < NDIG_WIDTH'(VALUE_WIDTH - 1))) begin
                     dividend_ff  <= div_result.quotient;
                     div_start_ff <= 1'b1;
                  end else begin
                     state_ff <= neg_ff ? ST_SIGN : ST_EMIT;
                  end
               end
            end
            ST_SIGN: begin
               rsp_valid_ff     <= 1'b1;
               rsp_character_ff <= MINUS_SIGN;
               rsp_last_ff      <= 1'b0;
               state_ff         <= ST_EMIT;
            end
            ST_EMIT: begin
               // Digits come off the stack most significant first.
               rsp_valid_ff     <= 1'b1;
               rsp_character_ff <= sym_table[digits_ff[top_index[STEP_WIDTH-1:0]]];
               rsp_last_ff      <= (ndig_ff == NDIG_WIDTH'(1));
               ndig_ff          <= top_index;
               if (ndig_ff == NDIG_WIDTH'(1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy          = (state_ff != ST_IDLE);
   assign div_start     = div_start_ff;
   assign div_dividend  = dividend_ff;
   assign div_divisor   = base_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

@@ hw/rtl/integer_to_radix_symbols_unit.sv @@
// Each digit takes a division in the shared bit-serial divider, then the output bytes (the
// sign, then the digits) are issued back to back; base 2 gives the most digits, the worst case.
// One request at a time: busy stays high from acceptance until the last byte is issued.
// Results appear as one-cycle strobes; the receiver cannot stall them.
// Synchronous active-high reset clears the sequencer and both alphabet registers.
`timescale 1ns / 1ps

module integer_to_radix_symbols_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [itrs_pkg::VALUE_WIDTH-1:0]      req_value,
   output logic                                  rsp_valid,
   output logic [itrs_pkg::CHAR_WIDTH-1:0]       rsp_character,
   output logic                                  rsp_last,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [itrs_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [itrs_pkg::CSR_WIDTH-1:0]        csr_data
);
   import itrs_pkg::*;

   logic [CSR_WIDTH-1:0]   symbols_low_ff;
   logic [CSR_WIDTH-1:0]   symbols_high_ff;
   sym_table_type          sym_table;
   logic [BASE_WIDTH-1:0]  base;
   logic                   div_start;
   logic [VALUE_WIDTH-1:0] div_dividend;
   logic [BASE_WIDTH-1:0]  div_divisor;
   div_result_type         div_result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         symbols_low_ff  <= '0;
         symbols_high_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SYMBOLS_LOW:  symbols_low_ff  <= csr_data;
            CSR_SYMBOLS_HIGH: symbols_high_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign sym_table = {symbols_high_ff, symbols_low_ff};

   itrs_alpha_check u_alpha_check (
      .sym_table (sym_table),
      .base      (base)
   );

   itrs_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .result   (div_result)
   );

   itrs_sequencer u_sequencer (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .base          (base),
      .sym_table     (sym_table),
      .div_start     (div_start),
      .div_dividend  (div_dividend),
      .div_divisor   (div_divisor),
      .div_result    (div_result),
      .rsp_valid     (rsp_valid),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

@@ hw/rtl/itrs_checker.sv @@
// Port-level checks on result sequencing of integer_to_radix_symbols_unit, bound to the top.
// Depends on itrs_pkg.
`timescale 1ns / 1ps

module itrs_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic                                  busy,
   input  logic                                  rsp_valid,
   input  logic [itrs_pkg::CHAR_WIDTH-1:0]       rsp_character,
   input  logic                                  rsp_last
);
   import itrs_pkg::*;

   // A new request needs at least one division before any byte can appear.
   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid)
      else $error("result issued right after a request was accepted");

   // Bytes of one run are issued on consecutive cycles.
   a_run_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=> rsp_valid)
      else $error("gap inside a result run");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> !rsp_valid)
      else $error("byte issued after the last byte of a run");

   a_busy_in_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> busy)
      else $error("unit idle while a result run is unfinished");

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (rsp_character != MINUS_SIGN))
      else $error("run ended on a minus sign");

endmodule

bind integer_to_radix_symbols_unit itrs_checker u_itrs_checker (.*);
